### sv/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg: shared types and constants for the vector field convolution
// Request and status codes, register indexes, default sizes, and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package vfc_pkg;

	localparam int DefMaxRows    = 64;
	localparam int DefMaxCols    = 64;
	localparam int DefMaxRadius  = 4;
	localparam int DefSampleBits = 16;

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 7;

	typedef enum logic [1:0] {
		REQ_COEF   = 2'd0,
		REQ_SAMPLE = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RADIUS0   = 2'd1,
		ST_RADIUSBIG = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BM_MIRROR     = 2'd0,
		BM_XPER_YMIR  = 2'd1,
		BM_XPER_YZERO = 2'd2,
		BM_ZERO       = 2'd3
	} border_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_HEIGHT = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_RADIUS = 2'd2,
		CFG_BORDER = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic accept;      // input transfer this cycle
		logic tap_en;      // step the tap sequencer
		logic load_result; // capture result into output register
	} vfc_cmd_t;

	typedef struct packed {
		logic query_ok; // incoming query passes all checks
		logic tap_last; // sequencer on last tap
		logic busy;     // taps still in flight
	} vfc_sts_t;

endpackage

### sv/vfc_if.sv
// ----------------------------------------------------------------------------
// vfc channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vfc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [5:0]  row_pos;
	logic [5:0]  col_pos;
	logic [6:0]  coef_index;
	logic signed [15:0] coef_value;
	logic signed [15:0] u_in;
	logic signed [15:0] v_in;
	modport source (output valid, req_type, row_pos, col_pos, coef_index, coef_value,
		u_in, v_in, input ready);
	modport sink (input valid, req_type, row_pos, col_pos, coef_index, coef_value,
		u_in, v_in, output ready);
endinterface

interface vfc_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] u_out;
	logic signed [15:0] v_out;
	logic [1:0]  status;
	modport source (output valid, u_out, v_out, status, input ready);
	modport sink (input valid, u_out, v_out, status, output ready);
endinterface

interface vfc_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [6:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/vfc_ctrl.sv
// ----------------------------------------------------------------------------
// vfc_ctrl: request controller
// Accepts requests, runs the tap sequence of a query, waits for the
// datapath pipe to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module vfc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_type,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  vfc_pkg::vfc_sts_t sts,
	output vfc_pkg::vfc_cmd_t cmd
);
	import vfc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_RUN    = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d         = state_q;
		cmd.accept      = accept;
		cmd.tap_en      = 1'b0;
		cmd.load_result = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req_type == REQ_QUERY)
					state_d = sts.query_ok ? S_RUN : S_FINISH;
			end
			S_RUN: begin
				cmd.tap_en = 1'b1;
				if (sts.tap_last)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!sts.busy)
					state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### sv/vfc_dp.sv
// ----------------------------------------------------------------------------
// vfc_dp: convolution datapath
// Registers, frame and mask memories, tap sequencer, border mapping,
// multiply-accumulate pipe and the rounded, saturated output register.
// ----------------------------------------------------------------------------
module vfc_dp #(
	parameter int MAX_ROWS    = vfc_pkg::DefMaxRows,
	parameter int MAX_COLS    = vfc_pkg::DefMaxCols,
	parameter int MAX_RADIUS  = vfc_pkg::DefMaxRadius,
	parameter int SAMPLE_BITS = vfc_pkg::DefSampleBits
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data,
	input  logic [1:0]         req_type,
	input  logic [5:0]         row_pos,
	input  logic [5:0]         col_pos,
	input  logic [6:0]         coef_index,
	input  logic signed [15:0] coef_value,
	input  logic signed [15:0] u_in,
	input  logic signed [15:0] v_in,
	input  vfc_pkg::vfc_cmd_t  cmd,
	output vfc_pkg::vfc_sts_t  sts,
	output logic signed [15:0] u_out,
	output logic signed [15:0] v_out,
	output logic [1:0]         status
);
	import vfc_pkg::*;

	localparam int MaskSide  = 2 * MAX_RADIUS + 1;
	localparam int MaskDepth = MaskSide * MaskSide;
	localparam int FrameDepth = MAX_ROWS * MAX_COLS;
	localparam int Sb        = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
	localparam int MaxDim    = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int DimLog    = ($clog2(MaxDim) > 7) ? $clog2(MaxDim) : 7;
	localparam int Cw        = DimLog + 2;
	localparam int Rw        = $clog2(MAX_RADIUS + 1) + 1;
	localparam int Kw        = $clog2(MaskDepth);
	localparam int Aw        = $clog2(FrameDepth);
	localparam int Riw       = $clog2(MAX_ROWS);
	localparam int Ciw       = $clog2(MAX_COLS);
	localparam int Pw        = 16 + Sb;
	localparam int Accw      = Pw + Kw + 1;

	// configuration
	logic [6:0] height_q, width_q;
	logic [2:0] radius_q;
	logic [1:0] border_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= 7'd64;
			width_q  <= 7'd64;
			radius_q <= 3'd2;
			border_q <= BM_MIRROR;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_RADIUS: radius_q <= cfg_data[2:0];
				CFG_BORDER: border_q <= cfg_data[1:0];
				default:    ;
			endcase
		end
	end

	// query checks
	logic signed [Cw-1:0] h_eff, w_eff, r3, row_c, col_c;
	logic [1:0]           stat_d;

	always_comb begin
		h_eff = (32'(height_q) > MAX_ROWS) ? Cw'(MAX_ROWS) : Cw'(height_q);
		w_eff = (32'(width_q) > MAX_COLS) ? Cw'(MAX_COLS) : Cw'(width_q);
		r3    = Cw'(radius_q) + Cw'(3);
		row_c = Cw'(row_pos);
		col_c = Cw'(col_pos);
		if (radius_q == 3'd0)
			stat_d = ST_RADIUS0;
		else if (32'(radius_q) > MAX_RADIUS || r3 >= (w_eff >>> 1) || r3 >= (h_eff >>> 1))
			stat_d = ST_RADIUSBIG;
		else if (row_c >= h_eff || col_c >= w_eff)
			stat_d = ST_RANGE;
		else
			stat_d = ST_OK;
	end

	assign sts.query_ok = (stat_d == ST_OK);

	// memories
	logic [2*Sb-1:0]    frame_mem_q [FrameDepth];
	logic signed [15:0] coef_mem_q [MaskDepth];
	logic [Aw-1:0]      wr_addr;

	assign wr_addr = Aw'(32'(row_pos) * MAX_COLS + 32'(col_pos));

	always_ff @(posedge clk) begin
		if (cmd.accept && req_type == REQ_SAMPLE && 32'(row_pos) < MAX_ROWS
			&& 32'(col_pos) < MAX_COLS)
			frame_mem_q[wr_addr] <= {u_in[Sb-1:0], v_in[Sb-1:0]};
		if (cmd.accept && req_type == REQ_COEF && 32'(coef_index) < MaskDepth)
			coef_mem_q[Kw'(coef_index)] <= coef_value;
	end

	// query context and tap sequencer
	logic signed [Cw-1:0] h_q, w_q, row_q, col_q;
	logic signed [Rw-1:0] r_q, dy_q, dx_q;
	logic [1:0]           stat_q, mode_q;
	logic [Kw-1:0]        kidx_q;
	logic                 start;

	assign start = cmd.accept && req_type == REQ_QUERY;

	always_ff @(posedge clk) begin
		if (start) begin
			h_q    <= h_eff;
			w_q    <= w_eff;
			row_q  <= row_c;
			col_q  <= col_c;
			r_q    <= Rw'(radius_q);
			dy_q   <= -Rw'(radius_q);
			dx_q   <= -Rw'(radius_q);
			kidx_q <= '0;
			stat_q <= stat_d;
			mode_q <= border_q;
		end else if (cmd.tap_en) begin
			kidx_q <= kidx_q + Kw'(1);
			if (dx_q == r_q) begin
				dx_q <= -r_q;
				dy_q <= dy_q + Rw'(1);
			end else begin
				dx_q <= dx_q + Rw'(1);
			end
		end
	end

	assign sts.tap_last = (dy_q == r_q) && (dx_q == r_q);

	// border mapping: {in frame, coordinate}
	function automatic logic [Cw:0] map_coord(logic signed [Cw-1:0] k,
		logic signed [Cw-1:0] n, logic mirror, logic periodic);
		logic signed [Cw-1:0] m;
		logic                 ok;
		m  = k;
		ok = 1'b1;
		if (k < 0 || k >= n) begin
			if (mirror)
				m = (k < 0) ? -k : ((n - Cw'(1)) <<< 1) - k;
			else
				m = (k < 0) ? k + n : k - n;
			ok = (mirror || periodic) && m >= 0 && m < n;
		end
		return {ok, m};
	endfunction

	logic [Cw:0]   my, mx;
	logic          ymir, xmir, xper;

	assign ymir = (mode_q == BM_MIRROR) || (mode_q == BM_XPER_YMIR);
	assign xmir = (mode_q == BM_MIRROR);
	assign xper = (mode_q == BM_XPER_YMIR) || (mode_q == BM_XPER_YZERO);
	assign my   = map_coord(row_q + Cw'(dy_q), h_q, ymir, 1'b0);
	assign mx   = map_coord(col_q + Cw'(dx_q), w_q, xmir, xper);

	// stage 1: mapped neighbor
	logic           vld_s1, vld_s2, vld_s3;
	logic [Riw-1:0] y_s1;
	logic [Ciw-1:0] x_s1;
	logic [Kw-1:0]  kidx_s1;

	// stage 2: memory data
	logic [2*Sb-1:0]    fdata_s2;
	logic signed [15:0] coef_s2;

	// stage 3: products
	logic signed [Pw-1:0] pu_s3, pv_s3;
	logic signed [Accw-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.tap_en && my[Cw] && mx[Cw];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		y_s1     <= my[Riw-1:0];
		x_s1     <= mx[Ciw-1:0];
		kidx_s1  <= kidx_q;
		fdata_s2 <= frame_mem_q[Aw'(32'(y_s1) * MAX_COLS + 32'(x_s1))];
		coef_s2  <= coef_mem_q[kidx_s1];
		pu_s3    <= coef_s2 * $signed(fdata_s2[2*Sb-1:Sb]);
		pv_s3    <= coef_s2 * $signed(fdata_s2[Sb-1:0]);
	end

	assign sts.busy = vld_s1 || vld_s2 || vld_s3;

	// accumulators: u in acc_q, v in accv_q
	logic signed [Accw-1:0] accv_q;

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			accv_q <= '0;
		end else if (vld_s3) begin
			acc_q  <= acc_q + Accw'(pu_s3);
			accv_q <= accv_q + Accw'(pv_s3);
		end
	end

	// round half up, drop 14 fraction bits, saturate
	function automatic logic signed [15:0] round_sat(logic signed [Accw-1:0] a);
		logic signed [Accw:0] t;
		logic signed [Accw:0] q;
		t = (Accw+1)'(a) + (Accw+1)'(8192);
		q = t >>> 14;
		if (q > (Accw+1)'(32767))
			return 16'sh7fff;
		else if (q < -(Accw+1)'(32768))
			return 16'sh8000;
		else
			return q[15:0];
	endfunction

	logic signed [15:0] u_out_q, v_out_q;
	logic [1:0]         status_q;

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			status_q <= stat_q;
			u_out_q  <= (stat_q == ST_OK) ? round_sat(acc_q) : 16'sd0;
			v_out_q  <= (stat_q == ST_OK) ? round_sat(accv_q) : 16'sd0;
		end
	end

	assign u_out  = u_out_q;
	assign v_out  = v_out_q;
	assign status = status_q;

endmodule

### sv/vector_field_conv2d_border.sv
// ----------------------------------------------------------------------------
// vector_field_conv2d_border: (u,v) field convolution with border modes
// Holds a frame of (u,v) samples and a square Q1.14 mask; answers pixel
// queries with the mask-weighted, rounded and saturated neighborhood sum.
// ----------------------------------------------------------------------------
// Channels: req carries coefficient loads, sample loads and queries; rsp
// returns one result per query (loads and unused request types give none);
// cfg writes height, width, radius and border mode and is always ready.
// A load is written at its transfer; the block stays ready for requests.
// A query that passes its checks steps one tap per cycle through the single
// frame memory read port, then the pipe drains and the output register is
// loaded. A query that fails its checks goes straight to that load.
// One query is in work at a time; new requests are taken again as soon as
// the result sits in the output register, even while the receiver stalls.
// If the output register is still full when the next result is ready the
// block holds it and stops taking requests until the transfer.
// Reset clears control state and the registers (64, 64, 2, mirror); frame
// and mask contents are undefined until written.
// ----------------------------------------------------------------------------
module vector_field_conv2d_border #(
	parameter int MAX_ROWS    = vfc_pkg::DefMaxRows,
	parameter int MAX_COLS    = vfc_pkg::DefMaxCols,
	parameter int MAX_RADIUS  = vfc_pkg::DefMaxRadius,
	parameter int SAMPLE_BITS = vfc_pkg::DefSampleBits
) (
	input  logic clk,
	input  logic arst_n,
	vfc_req_if.sink   req,
	vfc_rsp_if.source rsp,
	vfc_cfg_if.sink   cfg
);
	import vfc_pkg::*;

	vfc_cmd_t cmd;
	vfc_sts_t sts;

	assign cfg.ready = 1'b1;

	vfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	vfc_dp #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLS    (MAX_COLS),
		.MAX_RADIUS  (MAX_RADIUS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.req_type   (req.req_type),
		.row_pos    (req.row_pos),
		.col_pos    (req.col_pos),
		.coef_index (req.coef_index),
		.coef_value (req.coef_value),
		.u_in       (req.u_in),
		.v_in       (req.v_in),
		.cmd        (cmd),
		.sts        (sts),
		.u_out      (rsp.u_out),
		.v_out      (rsp.v_out),
		.status     (rsp.status)
	);

endmodule
